// ----- hw/rtl/i2cmra_pkg.sv -----
// Package for the I2C register access engine: op codes, phase enum, queue entry and result types.
// Used by i2cmra_front, i2cmra_back and the top level.
package i2cmra_pkg;
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE, PH_START_A, PH_START_B, PH_WR_LO, PH_WR_HI, PH_ACK_LO, PH_ACK_HI,
		PH_RSTART, PH_RD_LO, PH_RD_HI, PH_RA_HI, PH_RA_LO, PH_STOP_A, PH_STOP_B,
		PH_ERR_A, PH_ERR_B
	} phase_t;

	typedef struct packed {
		logic       cmd;
		logic       rd;
		logic [7:0] dev;
		logic [7:0] rg;
		logic [7:0] dat;
		logic [7:0] cnt;
		logic       sda;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic [7:0] read_byte;
		logic       byte_valid;
		logic       last_byte;
		logic       busy;
		logic       done;
		logic       status;
	} res_t;
endpackage

// ----- hw/rtl/i2cmra_front.sv -----
// Front end: accepts input items, classifies them, and queues them for the engine.
// Depends on i2cmra_pkg.
module i2cmra_front #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [7:0]        dev_byte,
	input  logic [7:0]        reg_byte,
	input  logic [7:0]        wr_data,
	input  logic [7:0]        count,
	input  logic              sda_in,
	output logic              q_valid,
	input  logic              q_ready,
	output i2cmra_pkg::item_t q_item
);
	import i2cmra_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	item_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	item_t cls;
	logic push, pop;

	always_comb begin
		cls.cmd = (op == OP_WRITE) || (op == OP_READ);
		cls.rd  = (op == OP_READ);
		cls.dev = dev_byte;
		cls.rg  = reg_byte;
		cls.dat = wr_data;
		cls.cnt = (count == 8'd0) ? 8'd1 : count;
		cls.sda = sda_in;
	end

	assign in_ready = (cnt_q != (AW+1)'(DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// ----- hw/rtl/i2cmra_back.sv -----
// Back end: I2C bus sequencer, one protocol step per queued item, with output register.
// Depends on i2cmra_pkg.
module i2cmra_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	input  logic              q_valid,
	output logic              q_ready,
	input  i2cmra_pkg::item_t q_item,
	output logic              out_valid,
	input  logic              out_ready,
	output i2cmra_pkg::res_t  res
);
	import i2cmra_pkg::*;
	phase_t phase_q, phase_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] sh_q, sh_d, left_q, left_d, dev_q, dev_d, rg_q, rg_d, dat_q, dat_d;
	logic [15:0] wait_q, wait_d, tmo_q;
	logic rd_q, rd_d;
	logic [1:0] stg_q, stg_d;
	logic [7:0] ld;
	logic [15:0] winc;
	logic step, last;
	res_t r;

	assign q_ready = !out_valid || out_ready;
	assign step    = q_valid && q_ready;
	assign last    = (left_q <= 8'd1);
	assign winc    = (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;

	always_comb begin
		case (stg_d)
			2'd0:    ld = dev_q;
			2'd1:    ld = rg_q;
			default: ld = rd_q ? dev_q + 8'd1 : dat_q;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		bit_d = bit_q; sh_d = sh_q; left_d = left_q; wait_d = wait_q;
		dev_d = dev_q; rg_d = rg_q; dat_d = dat_q; rd_d = rd_q; stg_d = stg_q;
		if (q_item.cmd && phase_q == PH_IDLE) begin
			dev_d = q_item.dev; rg_d = q_item.rg; dat_d = q_item.dat;
			left_d = q_item.cnt; rd_d = q_item.rd;
			stg_d = 2'd0; bit_d = '0; sh_d = '0; wait_d = '0;
			phase_d = PH_START_A;
		end else begin
			case (phase_q)
				PH_IDLE:    phase_d = PH_IDLE;
				PH_START_A: phase_d = PH_START_B;
				PH_START_B: begin
					sh_d = ld; bit_d = '0; phase_d = PH_WR_LO;
				end
				PH_WR_LO:   phase_d = PH_WR_HI;
				PH_WR_HI: begin
					sh_d = {sh_q[6:0], 1'b0};
					bit_d = bit_q + 4'd1;
					phase_d = (bit_q >= 4'd7) ? PH_ACK_LO : PH_WR_LO;
				end
				PH_ACK_LO: begin
					wait_d = '0; phase_d = PH_ACK_HI;
				end
				PH_ACK_HI: begin
					if (!q_item.sda) begin
						if (stg_q == 2'd0) begin
							stg_d = 2'd1; sh_d = ld; bit_d = '0; phase_d = PH_WR_LO;
						end else if (stg_q == 2'd1) begin
							stg_d = 2'd2;
							if (rd_q) begin
								phase_d = PH_RSTART;
							end else begin
								sh_d = ld; bit_d = '0; phase_d = PH_WR_LO;
							end
						end else if (rd_q) begin
							bit_d = '0; sh_d = '0; phase_d = PH_RD_LO;
						end else begin
							phase_d = PH_STOP_A;
						end
					end else begin
						wait_d = winc;
						if (winc >= tmo_q) begin
							phase_d = PH_ERR_A;
						end
					end
				end
				PH_RSTART:  phase_d = PH_START_A;
				PH_RD_LO:   phase_d = PH_RD_HI;
				PH_RD_HI: begin
					sh_d = {sh_q[6:0], q_item.sda};
					bit_d = bit_q + 4'd1;
					phase_d = (bit_q >= 4'd7) ? PH_RA_HI : PH_RD_LO;
				end
				PH_RA_HI:   phase_d = PH_RA_LO;
				PH_RA_LO: begin
					if (last) begin
						phase_d = PH_STOP_A;
					end else begin
						left_d = left_q - 8'd1; bit_d = '0; sh_d = '0; phase_d = PH_RD_LO;
					end
				end
				PH_STOP_A:  phase_d = PH_STOP_B;
				PH_ERR_A:   phase_d = PH_ERR_B;
				PH_STOP_B:  phase_d = PH_IDLE;
				PH_ERR_B:   phase_d = PH_IDLE;
				default:    phase_d = PH_IDLE;
			endcase
		end
	end

	always_comb begin
		r = '0;
		r.scl = 1'b1; r.sda_out = 1'b1; r.sda_drive = 1'b1;
		if (!(q_item.cmd && phase_q == PH_IDLE)) begin
			case (phase_q)
				PH_START_B: r.sda_out = 1'b0;
				PH_WR_LO: begin
					r.scl = 1'b0; r.sda_out = sh_q[7];
				end
				PH_WR_HI:   r.sda_out = sh_q[7];
				PH_ACK_LO: begin
					r.scl = 1'b0; r.sda_drive = 1'b0;
				end
				PH_ACK_HI:  r.sda_drive = 1'b0;
				PH_RSTART:  r.scl = 1'b0;
				PH_RD_LO: begin
					r.scl = 1'b0; r.sda_drive = 1'b0;
				end
				PH_RD_HI: begin
					r.sda_drive = 1'b0;
					if (bit_q >= 4'd7) begin
						r.byte_valid = 1'b1;
						r.read_byte = sh_d;
						r.last_byte = last;
					end
				end
				PH_RA_HI:   r.sda_out = last;
				PH_RA_LO: begin
					r.scl = 1'b0; r.sda_out = last;
				end
				PH_STOP_A, PH_ERR_A: begin
					r.scl = 1'b0; r.sda_out = 1'b0;
				end
				PH_STOP_B:  r.done = 1'b1;
				PH_ERR_B: begin
					r.done = 1'b1; r.status = 1'b1;
				end
				default:    r.scl = 1'b1;
			endcase
		end
		r.busy = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; bit_q <= '0; sh_q <= '0; left_q <= '0; wait_q <= '0;
			dev_q <= '0; rg_q <= '0; dat_q <= '0; rd_q <= 1'b0; stg_q <= '0;
			tmo_q <= 16'd1000; out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				tmo_q <= (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
			end
			if (step) begin
				phase_q <= phase_d; bit_q <= bit_d; sh_q <= sh_d; left_q <= left_d;
				wait_q <= wait_d; dev_q <= dev_d; rg_q <= rg_d; dat_q <= dat_d;
				rd_q <= rd_d; stg_q <= stg_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule

// ----- hw/rtl/i2c_master_register_access_top.sv -----
// Top level of the I2C register access engine: front queue and bus sequencer.
// Depends on i2cmra_pkg, i2cmra_front, i2cmra_back.
//
// Each input item (a command or a tick) yields exactly one result item giving the SCL/SDA
// levels for one bus delay unit; one item per clock is sustained while results are taken,
// limited by the single sequencer step per item. A queue of QUEUE_DEPTH (default two)
// entries separates intake from the sequencer, which stalls while a result is not taken.
module i2c_master_register_access_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  dev_byte,
	input  logic [7:0]  reg_byte,
	input  logic [7:0]  wr_data,
	input  logic [7:0]  count,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl,
	output logic        sda_out,
	output logic        sda_drive,
	output logic [7:0]  read_byte,
	output logic        byte_valid,
	output logic        last_byte,
	output logic        busy_res,
	output logic        done_res,
	output logic        status
);
	import i2cmra_pkg::*;
	logic q_valid, q_ready;
	item_t q_item;
	res_t res;

	i2cmra_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .op, .dev_byte, .reg_byte, .wr_data,
		.count, .sda_in, .q_valid, .q_ready, .q_item
	);

	i2cmra_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .q_valid, .q_ready, .q_item,
		.out_valid, .out_ready, .res
	);

	assign scl        = res.scl;
	assign sda_out    = res.sda_out;
	assign sda_drive  = res.sda_drive;
	assign read_byte  = res.read_byte;
	assign byte_valid = res.byte_valid;
	assign last_byte  = res.last_byte;
	assign busy_res   = res.busy;
	assign done_res   = res.done;
	assign status     = res.status;
endmodule

// ----- tb/tb_i2c_master_register_access_top.sv -----
// Testbench for i2c_master_register_access_top: drives commands and bus ticks over valid/ready
// and checks every result item against an in-house model of the I2C register access sequencer.
// Depends on i2cmra_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_i2c_master_register_access_top;
	import i2cmra_pkg::*;

	class i2c_scoreboard;
		phase_t     ph;
		bit   [3:0] bit_cnt;
		bit   [7:0] shreg;
		bit   [7:0] left;
		bit  [15:0] polls;
		bit  [15:0] ack_limit;
		bit   [7:0] dev;
		bit   [7:0] rg;
		bit   [7:0] dat;
		bit         rd;
		bit   [1:0] stage;
		res_t       pending[$];
		int         errors;

		function new();
			ph = PH_IDLE;
			bit_cnt = 0;
			shreg = 0;
			left = 0;
			polls = 0;
			ack_limit = 16'd1000;
			dev = 0;
			rg = 0;
			dat = 0;
			rd = 0;
			stage = 0;
			errors = 0;
		endfunction

		function void set_limit(bit [15:0] v);
			ack_limit = v;
		endfunction

		function void load_byte();
			if (stage == 0)
				shreg = dev;
			else if (stage == 1)
				shreg = rg;
			else if (rd)
				shreg = dev + 8'd1;
			else
				shreg = dat;
			bit_cnt = 0;
		endfunction

		function void note_item(bit [1:0] op, bit [7:0] d, bit [7:0] r, bit [7:0] w,
				bit [7:0] c, bit sda);
			res_t e;
			e = '0;
			e.scl = 1;
			e.sda_out = 1;
			e.sda_drive = 1;
			if ((op == OP_WRITE || op == OP_READ) && ph == PH_IDLE) begin
				dev = d;
				rg = r;
				dat = w;
				left = (c == 0) ? 8'd1 : c;
				rd = (op == OP_READ);
				stage = 0;
				bit_cnt = 0;
				shreg = 0;
				polls = 0;
				ph = PH_START_A;
			end else begin
				case (ph)
					PH_IDLE: ;
					PH_START_A: ph = PH_START_B;
					PH_START_B: begin
						e.sda_out = 0;
						load_byte();
						ph = PH_WR_LO;
					end
					PH_WR_LO: begin
						e.scl = 0;
						e.sda_out = shreg[7];
						ph = PH_WR_HI;
					end
					PH_WR_HI: begin
						e.sda_out = shreg[7];
						shreg = shreg << 1;
						bit_cnt++;
						ph = (bit_cnt >= 8) ? PH_ACK_LO : PH_WR_LO;
					end
					PH_ACK_LO: begin
						e.scl = 0;
						e.sda_drive = 0;
						polls = 0;
						ph = PH_ACK_HI;
					end
					PH_ACK_HI: begin
						e.sda_drive = 0;
						if (!sda) begin
							if (stage == 0) begin
								stage = 1;
								load_byte();
								ph = PH_WR_LO;
							end else if (stage == 1) begin
								stage = 2;
								if (rd)
									ph = PH_RSTART;
								else begin
									load_byte();
									ph = PH_WR_LO;
								end
							end else if (rd) begin
								bit_cnt = 0;
								shreg = 0;
								ph = PH_RD_LO;
							end else
								ph = PH_STOP_A;
						end else begin
							if (polls != 16'hFFFF)
								polls++;
							if (polls >= ack_limit)
								ph = PH_ERR_A;
						end
					end
					PH_RSTART: begin
						e.scl = 0;
						ph = PH_START_A;
					end
					PH_RD_LO: begin
						e.scl = 0;
						e.sda_drive = 0;
						ph = PH_RD_HI;
					end
					PH_RD_HI: begin
						e.sda_drive = 0;
						shreg = {shreg[6:0], sda};
						bit_cnt++;
						if (bit_cnt >= 8) begin
							e.byte_valid = 1;
							e.read_byte = shreg;
							e.last_byte = (left <= 1);
							ph = PH_RA_HI;
						end else
							ph = PH_RD_LO;
					end
					PH_RA_HI: begin
						e.sda_out = (left <= 1);
						ph = PH_RA_LO;
					end
					PH_RA_LO: begin
						e.scl = 0;
						e.sda_out = (left <= 1);
						if (left <= 1)
							ph = PH_STOP_A;
						else begin
							left--;
							bit_cnt = 0;
							shreg = 0;
							ph = PH_RD_LO;
						end
					end
					PH_STOP_A, PH_ERR_A: begin
						e.scl = 0;
						e.sda_out = 0;
						ph = (ph == PH_STOP_A) ? PH_STOP_B : PH_ERR_B;
					end
					PH_STOP_B: begin
						e.done = 1;
						ph = PH_IDLE;
					end
					PH_ERR_B: begin
						e.done = 1;
						e.status = 1;
						ph = PH_IDLE;
					end
					default: ph = PH_IDLE;
				endcase
			end
			e.busy = (ph != PH_IDLE);
			pending.push_back(e);
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result item %p", got);
				return;
			end
			e = pending.pop_front();
			if (got.scl !== e.scl || got.sda_out !== e.sda_out
					|| got.sda_drive !== e.sda_drive || got.read_byte !== e.read_byte
					|| got.byte_valid !== e.byte_valid || got.last_byte !== e.last_byte
					|| got.busy !== e.busy || got.done !== e.done
					|| got.status !== e.status) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %p actual %p", e, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [7:0]  dev_byte;
	logic [7:0]  reg_byte;
	logic [7:0]  wr_data;
	logic [7:0]  count;
	logic        sda_in;
	logic        out_valid;
	logic        out_ready;
	logic        scl;
	logic        sda_out;
	logic        sda_drive;
	logic [7:0]  read_byte;
	logic        byte_valid;
	logic        last_byte;
	logic        busy_res;
	logic        done_res;
	logic        status;
	res_t        got;

	i2c_scoreboard sb;
	int          idle_in;
	int          idle_out;
	int          ack_pct;
	longint      cycles;

	i2c_master_register_access_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .dev_byte(dev_byte),
		.reg_byte(reg_byte), .wr_data(wr_data), .count(count), .sda_in(sda_in),
		.out_valid(out_valid), .out_ready(out_ready), .scl(scl),
		.sda_out(sda_out), .sda_drive(sda_drive), .read_byte(read_byte),
		.byte_valid(byte_valid), .last_byte(last_byte), .busy_res(busy_res),
		.done_res(done_res), .status(status)
	);

	assign got = {scl, sda_out, sda_drive, read_byte, byte_valid, last_byte, busy_res,
		done_res, status};

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("i2c_master_register_access_top verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(got);
		out_ready <= ($urandom_range(99) >= idle_out);
	end

	task automatic send_item(bit [1:0] o, bit [7:0] d, bit [7:0] r, bit [7:0] w,
			bit [7:0] c, bit s);
		if ($urandom_range(99) < idle_in) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < idle_in)
				@(posedge clk);
		end
		in_valid <= 1;
		op <= o;
		dev_byte <= d;
		reg_byte <= r;
		wr_data <= w;
		count <= c;
		sda_in <= s;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_item(o, d, r, w, c, s);
	endtask

	// drive a random SDA level; in the ACK phase, ACK low with a set probability
	task automatic send_tick(bit [1:0] o);
		bit s;
		if (sb.ph == PH_ACK_HI)
			s = ($urandom_range(99) >= ack_pct);
		else
			s = $urandom_range(1);
		send_item(o, $urandom, $urandom, $urandom, $urandom, s);
	endtask

	task automatic run_transfer(bit [1:0] o, bit [7:0] d, bit [7:0] r, bit [7:0] w,
			bit [7:0] c);
		send_item(o, d, r, w, c, $urandom_range(1));
		while (sb.ph != PH_IDLE)
			send_tick($urandom_range(99) < 5 ? OP_UNUSED : OP_TICK);
	endtask

	task automatic random_items(int n);
		int k;
		bit [7:0] c;
		k = 0;
		while (k < n) begin
			if (sb.ph == PH_IDLE && $urandom_range(99) < 85) begin
				c = ($urandom_range(99) < 3) ? 8'($urandom) : 8'($urandom_range(3));
				send_item($urandom_range(1) ? OP_READ : OP_WRITE, $urandom, $urandom,
					$urandom, c, $urandom_range(1));
			end else if ($urandom_range(99) < 8)
				send_item($urandom_range(3), $urandom, $urandom, $urandom, $urandom,
					$urandom_range(1));
			else
				send_tick(OP_TICK);
			k++;
		end
	endtask

	task automatic settle_and_write(bit [15:0] v);
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_limit(v);
	endtask

	initial begin
		sb = new();
		cycles = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		in_valid = 0;
		op = OP_TICK;
		dev_byte = 0;
		reg_byte = 0;
		wr_data = 0;
		count = 0;
		sda_in = 0;
		out_ready = 0;
		idle_in = 0;
		idle_out = 0;
		ack_pct = 100;
		repeat (3)
			@(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		run_transfer(OP_WRITE, 8'hFF, 8'h00, 8'hFF, 8'h00);
		run_transfer(OP_READ, 8'hFF, 8'hFF, 8'h00, 8'h00);
		run_transfer(OP_READ, 8'h00, 8'h5A, 8'hA5, 8'h02);
		send_item(OP_WRITE, 8'hA0, 8'h10, 8'h33, 8'h01, 1'b0);
		send_item(OP_READ, 8'h11, 8'h22, 8'h44, 8'h05, 1'b1);
		run_transfer(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00);

		idle_in = 36;
		idle_out = 57;
		ack_pct = 70;
		settle_and_write(16'd1);
		random_items(150);
		settle_and_write(16'd3);
		random_items(100);

		idle_in = 57;
		idle_out = 36;
		ack_pct = 85;
		settle_and_write(16'd2);
		random_items(150);

		idle_in = 0;
		idle_out = 0;
		ack_pct = 95;
		settle_and_write(16'd65535);
		random_items(150);

		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (sb.errors == 0)
			$display("i2c_master_register_access_top verification clean");
		else
			$display("i2c_master_register_access_top verification failed");
		$finish;
	end
endmodule
